// File: hdl/dlc_pkg.sv
// Package: shared constants and payload types for the depth layer compositor.
`default_nettype none
package dlc_pkg;
  localparam int MaxLayersDef = 16;
  localparam int FarW = 31;
  localparam logic [FarW-1:0] FarDepthReset = 31'h42C80000;
  localparam int IdxW = 4;

  typedef struct packed {
    logic [23:0] color_rgb;
    logic [31:0] vertex_x;
    logic [31:0] vertex_y;
    logic [31:0] vertex_z;
    logic [31:0] normal_x;
    logic [31:0] normal_y;
    logic [31:0] normal_z;
    logic        last_layer;
  } in_item_t;

  typedef struct packed {
    logic [23:0]     out_color;
    logic [31:0]     out_vertex_x;
    logic [31:0]     out_vertex_y;
    logic [31:0]     out_vertex_z;
    logic [31:0]     out_normal_x;
    logic [31:0]     out_normal_y;
    logic [31:0]     out_normal_z;
    logic [IdxW-1:0] chosen_layer;
  } out_item_t;
endpackage
`default_nettype wire

// File: hdl/dlc_if.sv
// Interfaces: valid/ready channels for layer items, results and configuration.
`default_nettype none
interface dlc_in_if;
  logic               valid;
  logic               ready;
  dlc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dlc_out_if;
  logic               valid;
  logic               ready;
  dlc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dlc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [dlc_pkg::FarW-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/depth_layer_compositor_core.sv
// Top level: per-pixel nearest-layer compositor over a stream of layer items.
// Latency: a result is presented the cycle after its last layer transfers.
// Throughput: one layer per cycle while the output register is empty or being
// taken; the compare-and-select logic is combinational. The output register is refilled in the cycle it is taken.
// Reset clears the running best depth and index, layer count and output valid,
// and sets far depth to 100.0.
`default_nettype none
module depth_layer_compositor_core #(
  parameter int MAX_LAYERS = dlc_pkg::MaxLayersDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dlc_in_if.sink    in_ch,
  dlc_out_if.source out_ch,
  dlc_cfg_if.sink   cfg_ch
);
  localparam int CntW = (MAX_LAYERS > 2) ? $clog2(MAX_LAYERS) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_LAYERS - 1);

  logic [dlc_pkg::FarW-1:0] far_r;
  logic [31:0]              best_depth_r, best_depth_nxt;
  dlc_pkg::in_item_t        best_r, best_nxt;
  logic [CntW-1:0]          best_idx_r, best_idx_nxt;
  logic [CntW-1:0]          cnt_r, cnt_nxt;
  dlc_pkg::out_item_t       out_r, out_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic                     in_xfer, take, zvalid;
  logic [31:0]              depth, z;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_vld_r || out_ch.ready;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  // Substitute far depth for invalid depths, then compare
  always_comb begin
    z       = in_ch.data.vertex_z;
    zvalid  = !z[31] && (z != 32'd0) && (z[30:23] != 8'hFF);
    depth   = zvalid ? z : {1'b0, far_r};
    take    = (cnt_r == '0) || (depth < best_depth_r);
    best_depth_nxt = take ? depth : best_depth_r;
    best_nxt       = take ? in_ch.data : best_r;
    best_idx_nxt   = take ? cnt_r : best_idx_r;
    cnt_nxt        = (cnt_r < CntMax) ? cnt_r + 1'b1 : cnt_r;
    out_nxt.out_color    = best_nxt.color_rgb;
    out_nxt.out_vertex_x = best_nxt.vertex_x;
    out_nxt.out_vertex_y = best_nxt.vertex_y;
    out_nxt.out_vertex_z = best_nxt.vertex_z;
    out_nxt.out_normal_x = best_nxt.normal_x;
    out_nxt.out_normal_y = best_nxt.normal_y;
    out_nxt.out_normal_z = best_nxt.normal_z;
    out_nxt.chosen_layer = 4'(32'(best_idx_nxt));
    out_vld_nxt = (out_vld_r && !out_ch.ready) || (in_xfer && in_ch.data.last_layer);
  end

  // Hold far depth; update on a config transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_r <= dlc_pkg::FarDepthReset;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      far_r <= cfg_ch.data;
    end
  end

  // Advance running best; clear at end of pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      best_depth_r <= '0;
      best_idx_r   <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (in_xfer) begin
        if (in_ch.data.last_layer) begin
          cnt_r        <= '0;
          best_depth_r <= '0;
          best_idx_r   <= '0;
        end else begin
          cnt_r        <= cnt_nxt;
          best_depth_r <= best_depth_nxt;
          best_idx_r   <= best_idx_nxt;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      best_r <= best_nxt;
      if (in_ch.data.last_layer) begin
        out_r <= out_nxt;
      end
    end
  end
endmodule
`default_nettype wire
